FILE: design/spd_pkg.sv
// Shared types, constants and register codes of the spectrum peak decimator.
package spd_pkg;

   // Default sizes of the block
   localparam int DISPLAY_BINS_DEF = 256;
   localparam int MAX_FRAME_DEF    = 65536;

   // Fixed field widths
   localparam int LEVEL_W     = 16;
   localparam int FRAME_LEN_W = 17;
   localparam int RATE_W      = 32;
   localparam int TIME_W      = 32;
   localparam int BIN_IDX_W   = 8;

   // Shortest frame that is processed
   localparam int MIN_FRAME = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_DATA_W-1:0] INTERVAL_MS_RST = 16'd50;
   localparam logic [CSR_DATA_W-1:0] MIN_RANGE_RST   = 16'd2560;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERVAL_MS = 1'b0,
      CSR_MIN_RANGE   = 1'b1
   } spd_csr_type;

   // Sample opcodes
   localparam logic OP_DB   = 1'b0;
   localparam logic OP_NORM = 1'b1;

   // Request payload
   typedef struct packed {
      logic                      opcode;
      logic signed [LEVEL_W-1:0] sample_value;
      logic [FRAME_LEN_W-1:0]    frame_length;
      logic signed [LEVEL_W-1:0] floor_db;
      logic signed [LEVEL_W-1:0] ceil_db;
      logic [RATE_W-1:0]         sample_rate;
      logic [TIME_W-1:0]         time_ms;
   } spd_req_type;

   // Response payload
   typedef struct packed {
      logic [BIN_IDX_W-1:0]      bin_index;
      logic signed [LEVEL_W-1:0] bin_value;
      logic                      last_bin;
      logic                      history_reset;
   } spd_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic calc;
      logic advance;
      logic emit;
   } spd_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic busy;
      logic len_ok;
      logic emit_due;
      logic out_free;
   } spd_sts_type;

endpackage

FILE: design/spd_ctrl.sv
// Sequencer of the spectrum peak decimator: request intake and bin emit loop.
module spd_ctrl
   import spd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  spd_sts_type sts,
   output spd_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;
   logic      accept;

   assign req_stall = stall_ff;
   assign accept    = req_valid && !stall_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = accept;
            if (accept && (sts.busy || sts.len_ok)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.calc = 1'b1;
            if (sts.emit_due) begin
               state_in = ST_EMIT;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_EMIT: begin
            cmd.emit = sts.out_free;
            if (sts.out_free) begin
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the registered stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
      end
   end

endmodule

FILE: design/spd_datapath.sv
// Datapath of the spectrum peak decimator: frame state, bin bounds, peak and level.
module spd_datapath
   import spd_pkg::*;
#(
   parameter int DISPLAY_BINS = DISPLAY_BINS_DEF,
   parameter int MAX_FRAME    = MAX_FRAME_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  spd_req_type           req_data,
   input  spd_cmd_type           cmd,
   output spd_sts_type           sts,
   input  logic [CSR_DATA_W-1:0] interval_ms,
   input  logic [CSR_DATA_W-1:0] min_range,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spd_rsp_type           rsp_data
);

   localparam int LEN_W  = $clog2(MAX_FRAME + 1);
   localparam int BIN_W  = $clog2(DISPLAY_BINS + 1);
   localparam int ACC_W  = $clog2((MAX_FRAME + 2) * (DISPLAY_BINS + 1));
   localparam int PEAK_W = 15;
   localparam int SPAN_W = LEVEL_W + 1;
   localparam int PROD_W = PEAK_W + LEVEL_W;
   localparam int Q14_SHIFT = 14;
   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(8192);
   localparam logic signed [LEVEL_W-1:0] ONE_Q14 = 16'sd16384;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sh7FFF;

   // Clamp a normalized value to one and fold it into a peak
   function automatic logic signed [LEVEL_W-1:0] fold_peak(
      input logic signed [LEVEL_W-1:0] peak,
      input logic signed [LEVEL_W-1:0] value,
      input logic                      norm
   );
      logic signed [LEVEL_W-1:0] clipped;
      clipped = (norm && (value > ONE_Q14)) ? ONE_Q14 : value;
      return (clipped > peak) ? clipped : peak;
   endfunction

   // Control state
   logic                 busy_ff, busy_in;
   logic                 taken_ff, taken_in;
   logic                 have_ff, have_in;
   logic                 pending_ff, pending_in;
   logic [TIME_W-1:0]    last_time_ff, last_time_in;
   logic [RATE_W-1:0]    last_rate_ff, last_rate_in;
   logic [LEN_W-1:0]     count_ff, count_in;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [LEN_W-1:0]          held_len_ff, held_len_in;
   logic                      held_mode_ff, held_mode_in;
   logic signed [LEVEL_W-1:0] held_floor_ff, held_floor_in;
   logic signed [LEVEL_W-1:0] held_ceil_ff, held_ceil_in;
   logic signed [LEVEL_W-1:0] peak_ff, peak_in;
   logic signed [LEVEL_W-1:0] sample_ff, sample_in;
   logic [ACC_W-1:0]          bn_ff, bn_in;
   logic [ACC_W-1:0]          bn1_ff, bn1_in;
   logic [ACC_W-1:0]          sb1_ff, sb1_in;
   logic [ACC_W-1:0]          sb2_ff, sb2_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   spd_rsp_type               rsp_data_ff, rsp_data_in;

   // Intermediate logic
   logic                      len_ok;
   logic                      start;
   logic                      fold_now;
   logic                      req_norm;
   logic                      throttled;
   logic [TIME_W-1:0]         elapsed;
   logic signed [LEVEL_W-1:0] start_peak;
   logic signed [LEVEL_W-1:0] held_peak;
   logic signed [SPAN_W-1:0]  span;
   logic signed [SPAN_W-1:0]  span_min;
   logic [LEVEL_W-1:0]        range_sel;
   logic [PROD_W:0]           rounded;
   logic [PROD_W-Q14_SHIFT:0] scaled;
   logic [LEVEL_W-1:0]        scaled_sat;
   logic signed [LEVEL_W+1:0] level_sum;
   logic signed [LEVEL_W-1:0] level;
   logic [LEN_W-1:0]          count_nxt;
   logic                      emit_due;
   logic                      out_free;

   // Frame start checks
   assign len_ok    = (req_data.frame_length >= FRAME_LEN_W'(MIN_FRAME)) &&
                      (req_data.frame_length <= FRAME_LEN_W'(MAX_FRAME));
   assign start     = cmd.accept && !busy_ff && len_ok;
   assign fold_now  = cmd.accept && busy_ff;
   assign req_norm  = (req_data.opcode == OP_NORM);
   assign elapsed   = req_data.time_ms - last_time_ff;
   assign throttled = have_ff && (elapsed < TIME_W'(interval_ms));
   assign start_peak = req_norm ? '0 : req_data.floor_db;
   assign held_peak  = (held_mode_ff == OP_NORM) ? '0 : held_floor_ff;

   // Bin closes on this sample when first <= s and next first <= s+1
   assign emit_due = taken_ff && (bin_ff < BIN_W'(DISPLAY_BINS)) &&
                     (bn_ff < sb1_ff) && (bn1_ff < sb2_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Normalized span, widened to the minimum range
   assign span      = {held_ceil_ff[LEVEL_W-1], held_ceil_ff} -
                      {held_floor_ff[LEVEL_W-1], held_floor_ff};
   assign span_min  = {1'b0, min_range};
   assign range_sel = (span < span_min) ? min_range : span[LEVEL_W-1:0];

   // Round the registered product to Q8.8 and add the floor
   assign rounded    = {1'b0, prod_ff} + ROUND_HALF;
   assign scaled     = rounded[PROD_W:Q14_SHIFT];
   assign scaled_sat = (scaled > (PROD_W - Q14_SHIFT + 1)'(16'hFFFF)) ?
                       16'hFFFF : scaled[LEVEL_W-1:0];
   assign level_sum  = {{2{held_floor_ff[LEVEL_W-1]}}, held_floor_ff} + {2'b00, scaled_sat};
   assign level      = (held_mode_ff != OP_NORM) ? peak_ff :
                       (level_sum > (LEVEL_W + 2)'(signed'(LEVEL_MAX))) ? LEVEL_MAX :
                       level_sum[LEVEL_W-1:0];

   assign count_nxt = count_ff + 1'b1;

   always_comb begin
      busy_in       = busy_ff;
      taken_in      = taken_ff;
      have_in       = have_ff;
      pending_in    = pending_ff;
      last_time_in  = last_time_ff;
      last_rate_in  = last_rate_ff;
      count_in      = count_ff;
      bin_in        = bin_ff;
      rsp_valid_in  = rsp_valid_ff;
      held_len_in   = held_len_ff;
      held_mode_in  = held_mode_ff;
      held_floor_in = held_floor_ff;
      held_ceil_in  = held_ceil_ff;
      peak_in       = peak_ff;
      sample_in     = sample_ff;
      bn_in         = bn_ff;
      bn1_in        = bn1_ff;
      sb1_in        = sb1_ff;
      sb2_in        = sb2_ff;
      prod_in       = prod_ff;
      rsp_data_in   = rsp_data_ff;

      // Hold the sample of the request
      if (cmd.accept) begin
         sample_in = req_data.sample_value;
      end

      // Open a frame: latch its header and decide on throttling
      if (start) begin
         busy_in       = 1'b1;
         count_in      = '0;
         bin_in        = '0;
         held_len_in   = LEN_W'(req_data.frame_length);
         held_mode_in  = req_norm;
         held_floor_in = req_data.floor_db;
         held_ceil_in  = req_data.ceil_db;
         taken_in      = !throttled;
         if (!throttled) begin
            pending_in   = (last_rate_ff != '0) && (last_rate_ff != req_data.sample_rate);
            last_rate_in = req_data.sample_rate;
            last_time_in = req_data.time_ms;
            have_in      = 1'b1;
         end
         peak_in = fold_peak(start_peak, req_data.sample_value, req_norm);
         bn_in   = '0;
         bn1_in  = ACC_W'(LEN_W'(req_data.frame_length));
         sb1_in  = ACC_W'(DISPLAY_BINS);
         sb2_in  = ACC_W'(2 * DISPLAY_BINS);
      end

      // Fold a later sample of the frame
      if (fold_now) begin
         peak_in = fold_peak(peak_ff, req_data.sample_value, held_mode_ff);
      end

      // Scale the peak by the span
      if (cmd.calc) begin
         prod_in = PROD_W'(peak_ff[PEAK_W-1:0]) * PROD_W'(range_sel);
      end

      // Advance to the next sample, close the frame at its end
      if (cmd.advance) begin
         sb1_in = sb1_ff + ACC_W'(DISPLAY_BINS);
         sb2_in = sb2_ff + ACC_W'(DISPLAY_BINS);
         if (count_nxt >= held_len_ff) begin
            busy_in  = 1'b0;
            count_in = '0;
            bin_in   = '0;
         end else begin
            count_in = count_nxt;
         end
      end

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Emit the bin and open the next one
      if (cmd.emit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.bin_index     = BIN_IDX_W'(bin_ff);
         rsp_data_in.bin_value     = level;
         rsp_data_in.last_bin      = (bin_ff == BIN_W'(DISPLAY_BINS - 1));
         rsp_data_in.history_reset = (bin_ff == '0) && pending_ff;
         if (bin_ff == '0) begin
            pending_in = 1'b0;
         end
         bin_in  = bin_ff + 1'b1;
         bn_in   = bn1_ff;
         bn1_in  = bn1_ff + ACC_W'(held_len_ff);
         peak_in = (bn1_ff < sb1_ff) ? fold_peak(held_peak, sample_ff, held_mode_ff) :
                   held_peak;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         taken_ff     <= 1'b0;
         have_ff      <= 1'b0;
         pending_ff   <= 1'b0;
         last_time_ff <= '0;
         last_rate_ff <= '0;
         count_ff     <= '0;
         bin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         taken_ff     <= taken_in;
         have_ff      <= have_in;
         pending_ff   <= pending_in;
         last_time_ff <= last_time_in;
         last_rate_ff <= last_rate_in;
         count_ff     <= count_in;
         bin_ff       <= bin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      held_len_ff   <= held_len_in;
      held_mode_ff  <= held_mode_in;
      held_floor_ff <= held_floor_in;
      held_ceil_ff  <= held_ceil_in;
      peak_ff       <= peak_in;
      sample_ff     <= sample_in;
      bn_ff         <= bn_in;
      bn1_ff        <= bn1_in;
      sb1_ff        <= sb1_in;
      sb2_ff        <= sb2_in;
      prod_ff       <= prod_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.len_ok   = len_ok;
   assign sts.emit_due = emit_due;
   assign sts.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/spectrum_peak_decimator_core.sv
// Top level of the spectrum peak decimator: configuration registers, sequencer, datapath.
//
// Spectrum frames enter one sample per request and leave as DISPLAY_BINS peak-held
// display bins, one response per bin, in bin order; a frame that opens less than
// interval_ms after the last taken frame yields none. A sample is accepted in idle,
// then checked; each closed bin adds a pass through the emit state (which waits while
// the response side stalls) and another check. A frame-opening sample with a bad length
// is dropped at intake. The loop moves one bin per pass through the single output
// register. Bin bounds use running sums of bin*length and sample*bins, not a divider.
module spectrum_peak_decimator_core
   import spd_pkg::*;
#(
   parameter int DISPLAY_BINS = DISPLAY_BINS_DEF,
   parameter int MAX_FRAME    = MAX_FRAME_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spd_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spd_rsp_type           rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CSR_DATA_W-1:0] interval_ms_ff;
   logic [CSR_DATA_W-1:0] min_range_ff;
   spd_cmd_type           cmd;
   spd_sts_type           sts;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ms_ff <= INTERVAL_MS_RST;
         min_range_ff   <= MIN_RANGE_RST;
      end else if (csr_wr_en) begin
         case (spd_csr_type'(csr_index))
            CSR_INTERVAL_MS: interval_ms_ff <= csr_wdata;
            CSR_MIN_RANGE:   min_range_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   spd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   spd_datapath #(
      .DISPLAY_BINS (DISPLAY_BINS),
      .MAX_FRAME    (MAX_FRAME)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .interval_ms (interval_ms_ff),
      .min_range   (min_range_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
